>>> sv/blr_pkg.sv
`default_nettype none

package blr_pkg;

    localparam int MAX_DIGITS_DEF  = 5;
    localparam int CELLS_PER_DIGIT = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [2:0] CELL_LAST     = 3'd5;
    localparam logic [2:0] CELL_ROW_SPLIT = 3'd3;
    localparam logic [7:0] SPACE_CODE    = 8'd32;
    localparam logic [7:0] BLANK_CODE    = 8'd254;
    localparam logic [7:0] COLS_PER_DIGIT = 8'd3;

    // Reciprocal of 10 scaled by 2^19; exact quotient for every 16-bit dividend
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    localparam int CFG_DATA_W = 3;
    localparam logic [0:0] REG_DIGIT_COUNT = 1'b0;
    localparam logic [0:0] REG_SHOW_LZ     = 1'b1;

    localparam logic [2:0] DIGIT_COUNT_RST = 3'd5;
    localparam logic       SHOW_LZ_RST     = 1'b0;

    typedef struct packed {
        logic signed [15:0] value;
        logic [7:0]         start_column;
    } in_t;

    typedef struct packed {
        logic       cell_row;
        logic [7:0] cell_column;
        logic [7:0] char_code;
        logic       last_cell;
    } out_t;

    typedef struct packed {
        logic [2:0] digit_count;
        logic       show_leading_zeros;
    } cfg_t;

    localparam logic [7:0] GLYPH [10][6] = '{
        '{8'd0,   8'd1,   8'd2, 8'd0,   8'd4,   8'd2},
        '{8'd254, 8'd254, 8'd2, 8'd254, 8'd254, 8'd2},
        '{8'd3,   8'd6,   8'd2, 8'd0,   8'd4,   8'd4},
        '{8'd3,   8'd6,   8'd2, 8'd7,   8'd4,   8'd2},
        '{8'd0,   8'd4,   8'd2, 8'd254, 8'd254, 8'd2},
        '{8'd0,   8'd6,   8'd5, 8'd7,   8'd4,   8'd2},
        '{8'd0,   8'd6,   8'd5, 8'd0,   8'd4,   8'd2},
        '{8'd1,   8'd1,   8'd2, 8'd254, 8'd254, 8'd2},
        '{8'd0,   8'd6,   8'd2, 8'd0,   8'd4,   8'd2},
        '{8'd0,   8'd6,   8'd2, 8'd7,   8'd4,   8'd2}
    };

    function automatic logic [7:0] glyph_code(logic [3:0] digit, logic [2:0] slot);
        logic [7:0] code;
        code = BLANK_CODE;
        if (digit <= 4'd9 && slot <= CELL_LAST) begin
            code = GLYPH[digit][slot];
        end
        return code;
    endfunction

endpackage

`default_nettype wire

>>> sv/blr_front.sv
`default_nettype none

module blr_front #(
    parameter int MAX_DIGITS = blr_pkg::MAX_DIGITS_DEF,
    localparam int CW  = $clog2(MAX_DIGITS + 1),
    localparam int DIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
    localparam int JW  = 1 + 8 + CW + 4 * MAX_DIGITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire blr_pkg::cfg_t cfg,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire blr_pkg::in_t  s_data,
    output logic               q_valid,
    input  wire logic          q_ready,
    output logic [JW-1:0]      q_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_t;

    state_t                       state_reg, state_next;
    logic [15:0]                  mag_reg, mag_next;
    logic [DIW-1:0]               pos_reg, pos_next;
    logic [MAX_DIGITS-1:0][3:0]   dig_reg, dig_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [7:0]                   start_reg, start_next;
    logic                         lz_reg, lz_next;

    logic [31:0] prod;
    logic [15:0] quot;
    logic [15:0] rem_full;
    logic [CW-1:0] count_sat;

    always_comb begin
        prod     = 32'(mag_reg) * 32'(blr_pkg::DIV10_MUL);
        quot     = 16'(prod >> blr_pkg::DIV10_SHIFT);
        rem_full = mag_reg - ((quot << 3) + (quot << 1));

        if (cfg.digit_count == 3'd0) begin
            count_sat = CW'(1);
        end else if (int'(cfg.digit_count) > MAX_DIGITS) begin
            count_sat = CW'(MAX_DIGITS);
        end else begin
            count_sat = CW'(cfg.digit_count);
        end
    end

    assign s_ready = (state_reg == ST_IDLE) || (state_reg == ST_PUSH && q_ready);
    assign q_valid = (state_reg == ST_PUSH);
    assign q_data  = {lz_reg, start_reg, count_reg, dig_reg};

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        pos_next   = pos_reg;
        dig_next   = dig_reg;
        count_next = count_reg;
        start_next = start_reg;
        lz_next    = lz_reg;

        case (state_reg)
            ST_CONV: begin
                // least significant digit lands in the rightmost position
                dig_next[pos_reg] = rem_full[3:0];
                mag_next = quot;
                if (pos_reg == '0) begin
                    state_next = ST_PUSH;
                end else begin
                    pos_next = pos_reg - DIW'(1);
                end
            end
            ST_PUSH: begin
                if (q_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: ;
        endcase

        if (s_valid && s_ready) begin
            mag_next   = s_data.value[15] ? 16'(-s_data.value) : 16'(s_data.value);
            count_next = count_sat;
            pos_next   = DIW'(count_sat - CW'(1));
            start_next = s_data.start_column;
            lz_next    = cfg.show_leading_zeros;
            state_next = ST_CONV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg   <= mag_next;
        pos_reg   <= pos_next;
        dig_reg   <= dig_next;
        count_reg <= count_next;
        start_reg <= start_next;
        lz_reg    <= lz_next;
    end

endmodule

`default_nettype wire

>>> sv/blr_queue.sv
`default_nettype none

module blr_queue #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic [W-1:0] mem [blr_pkg::QUEUE_DEPTH];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   fill_reg, fill_next;
    logic         push, pop;

    assign in_ready  = (fill_reg != 2'(blr_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/blr_back.sv
`default_nettype none

module blr_back #(
    parameter int MAX_DIGITS = blr_pkg::MAX_DIGITS_DEF,
    localparam int CW  = $clog2(MAX_DIGITS + 1),
    localparam int DIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
    localparam int JW  = 1 + 8 + CW + 4 * MAX_DIGITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire logic [JW-1:0] q_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output blr_pkg::out_t      m_data
);

    logic                       active_reg, active_next;
    logic [MAX_DIGITS-1:0][3:0] dig_reg, dig_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [7:0]                 col_reg, col_next;
    logic                       drawing_reg, drawing_next;
    logic [DIW-1:0]             pos_reg, pos_next;
    logic [2:0]                 cell_reg, cell_next;
    logic                       m_valid_reg, m_valid_next;
    blr_pkg::out_t              m_data_reg, m_data_next;

    logic       emit;
    logic       last;
    logic       blank;
    logic [3:0] cur_dig;
    logic [2:0] cell_col;

    logic                       q_lz;
    logic [7:0]                 q_start;
    logic [CW-1:0]              q_count;
    logic [MAX_DIGITS-1:0][3:0] q_dig;

    assign {q_lz, q_start, q_count, q_dig} = q_data;

    assign emit     = active_reg && (!m_valid_reg || m_ready);
    assign cur_dig  = dig_reg[pos_reg];
    assign last     = (CW'(pos_reg) + CW'(1) == count_reg) && (cell_reg == blr_pkg::CELL_LAST);
    assign blank    = (cur_dig == 4'd0) && !drawing_reg && (CW'(pos_reg) + CW'(1) != count_reg);
    assign cell_col = (cell_reg >= blr_pkg::CELL_ROW_SPLIT) ?
                      cell_reg - blr_pkg::CELL_ROW_SPLIT : cell_reg;
    // take the next job while the last cell of the current one goes out
    assign q_ready  = !active_reg || (emit && last);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        active_next  = active_reg;
        dig_next     = dig_reg;
        count_next   = count_reg;
        col_next     = col_reg;
        drawing_next = drawing_reg;
        pos_next     = pos_reg;
        cell_next    = cell_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (emit) begin
            m_valid_next             = 1'b1;
            m_data_next.cell_row     = (cell_reg >= blr_pkg::CELL_ROW_SPLIT);
            m_data_next.cell_column  = col_reg + 8'(cell_col);
            m_data_next.char_code    = blank ? blr_pkg::SPACE_CODE :
                                       blr_pkg::glyph_code(cur_dig, cell_reg);
            m_data_next.last_cell    = last;
            drawing_next = drawing_reg || !blank;
            if (cell_reg == blr_pkg::CELL_LAST) begin
                cell_next = 3'd0;
                pos_next  = pos_reg + DIW'(1);
                col_next  = col_reg + blr_pkg::COLS_PER_DIGIT;
            end else begin
                cell_next = cell_reg + 3'd1;
            end
            if (last) begin
                active_next = 1'b0;
            end
        end

        if (q_valid && q_ready) begin
            active_next  = 1'b1;
            dig_next     = q_dig;
            count_next   = q_count;
            col_next     = q_start;
            drawing_next = q_lz;
            pos_next     = '0;
            cell_next    = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
            cell_reg    <= 3'd0;
            count_reg   <= CW'(1);
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
            cell_reg    <= cell_next;
            count_reg   <= count_next;
        end
        dig_reg     <= dig_next;
        col_reg     <= col_next;
        drawing_reg <= drawing_next;
        m_data_reg  <= m_data_next;
    end

    a_cell_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> cell_reg <= blr_pkg::CELL_LAST)
        else $error("cell counter out of range");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> CW'(pos_reg) < count_reg)
        else $error("digit position beyond digit count");

    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> active_reg && pos_reg == '0 && cell_reg == 3'd0)
        else $error("popped job did not start at first cell");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last && !q_valid) |=> !active_reg && m_valid && m_data.last_cell)
        else $error("final cell did not close the job");

endmodule

`default_nettype wire

>>> sv/big_digit_lcd_renderer.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   blr_pkg::in_t  (value, start_column)
// m_        out        m_valid / m_ready   blr_pkg::out_t (cell_row, cell_column,
//                                                          char_code, last_cell)
// cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// Each transaction in yields 6 * digit_count transactions out, one per cycle
// while m_ready is high, all through the single output register; digit_count
// is clamped to 1..MAX_DIGITS. Digit conversion in the front end overlaps the
// previous item's output through a 2-entry queue.
// Reset is synchronous on aresetn low: digit_count = 5, show_leading_zeros = 0.
// A stalled m_ready backs up into the queue, then into s_ready.
module big_digit_lcd_renderer #(
    parameter int MAX_DIGITS = blr_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire blr_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output blr_pkg::out_t                      m_data,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [blr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int JW = 1 + 8 + CW + 4 * MAX_DIGITS;

    logic [2:0]    digit_count_reg;
    logic          show_lz_reg;
    blr_pkg::cfg_t cfg;

    logic          fq_valid, fq_ready;
    logic [JW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [JW-1:0] qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= blr_pkg::DIGIT_COUNT_RST;
            show_lz_reg     <= blr_pkg::SHOW_LZ_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                blr_pkg::REG_DIGIT_COUNT: digit_count_reg <= cfg_wdata[2:0];
                blr_pkg::REG_SHOW_LZ:     show_lz_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg.digit_count        = digit_count_reg;
    assign cfg.show_leading_zeros = show_lz_reg;

    blr_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    blr_queue #(.W(JW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    blr_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
